FILE: hw/rtl/pfit_pkg.sv
// Package for the three-point parabola fit: widths, fraction sizes and the
// sideband word that travels down the divider cell chain. No dependencies.
package pfit_pkg;

   // coordinate bits actually used (low bits of each 12-bit field)
   localparam int COORD_BITS    = 12;
   localparam int FIELD_W       = 12;
   localparam int COEF_W        = 64;
   localparam int FRAC_SQUARE   = 40;
   localparam int FRAC_LINEAR   = 24;
   localparam int FRAC_CONSTANT = 16;
   localparam int LANES         = 3;

   localparam int DIF_W  = COORD_BITS + 1;          // signed difference
   localparam int PRD_W  = 2 * COORD_BITS + 2;      // signed product of two
   localparam int SQR_W  = 2 * COORD_BITS;          // unsigned product of two
   localparam int NUMA_W = 2 * COORD_BITS + 4;
   localparam int TRM_W  = 3 * COORD_BITS + 2;
   localparam int DENS_W = 3 * COORD_BITS + 3;
   localparam int NUMB_W = 3 * COORD_BITS + 4;
   localparam int CTRM_W = 4 * COORD_BITS + 4;
   localparam int NUMC_W = 4 * COORD_BITS + 6;
   localparam int DEN_W  = 3 * COORD_BITS;          // divisor magnitude

   function automatic int max_of(input int a, input int b);
      max_of = (a > b) ? a : b;
   endfunction

   // dividend / quotient width: widest scaled numerator, at least 65 bits
   localparam int MAG_W = max_of(max_of(max_of(NUMA_W + FRAC_SQUARE,
      NUMB_W + FRAC_LINEAR), NUMC_W + FRAC_CONSTANT), COEF_W + 1);

   typedef struct packed {
      logic              vld;
      logic              degen;
      logic [LANES-1:0]  neg;
      logic [DEN_W-1:0]  den;
   } pfit_side_type;

endpackage

FILE: hw/rtl/pfit_front.sv
// Front end of the parabola fit: differences, products, numerators and the
// denominator, then sign/magnitude split and fraction scaling. Uses pfit_pkg.
module pfit_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      take,
   input  logic [pfit_pkg::FIELD_W-1:0]              x_first,
   input  logic [pfit_pkg::FIELD_W-1:0]              y_first,
   input  logic [pfit_pkg::FIELD_W-1:0]              x_second,
   input  logic [pfit_pkg::FIELD_W-1:0]              y_second,
   input  logic [pfit_pkg::FIELD_W-1:0]              x_third,
   input  logic [pfit_pkg::FIELD_W-1:0]              y_third,
   output pfit_pkg::pfit_side_type                   side_o,
   output logic [pfit_pkg::LANES-1:0][pfit_pkg::MAG_W-1:0] quo_o
);
   import pfit_pkg::*;

   // stage 0: masked coordinates and differences
   logic [COORD_BITS-1:0] x1_in, x2_in, x3_in, y1_in, y2_in, y3_in;
   logic [COORD_BITS-1:0] x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff;
   logic signed [DIF_W-1:0] d12_ff, d13_ff, d23_ff, d31_ff;
   logic signed [DIF_W-1:0] e12_ff, e31_ff, e23_ff, f21_ff, f13_ff, f32_ff;
   logic v0_ff, g0_ff;

   assign x1_in = COORD_BITS'(x_first);
   assign x2_in = COORD_BITS'(x_second);
   assign x3_in = COORD_BITS'(x_third);
   assign y1_in = COORD_BITS'(y_first);
   assign y2_in = COORD_BITS'(y_second);
   assign y3_in = COORD_BITS'(y_third);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= take;
      end
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      x3_ff  <= x3_in;
      y1_ff  <= y1_in;
      y2_ff  <= y2_in;
      y3_ff  <= y3_in;
      g0_ff  <= (x1_in == x2_in) || (x1_in == x3_in) || (x2_in == x3_in);
      d12_ff <= $signed({1'b0, x1_in}) - $signed({1'b0, x2_in});
      d13_ff <= $signed({1'b0, x1_in}) - $signed({1'b0, x3_in});
      d23_ff <= $signed({1'b0, x2_in}) - $signed({1'b0, x3_in});
      d31_ff <= $signed({1'b0, x3_in}) - $signed({1'b0, x1_in});
      e12_ff <= $signed({1'b0, y1_in}) - $signed({1'b0, y2_in});
      e31_ff <= $signed({1'b0, y3_in}) - $signed({1'b0, y1_in});
      e23_ff <= $signed({1'b0, y2_in}) - $signed({1'b0, y3_in});
      f21_ff <= $signed({1'b0, y2_in}) - $signed({1'b0, y1_in});
      f13_ff <= $signed({1'b0, y1_in}) - $signed({1'b0, y3_in});
      f32_ff <= $signed({1'b0, y3_in}) - $signed({1'b0, y2_in});
   end

   // stage 1: first products
   logic signed [PRD_W-1:0] pa1_ff, pa2_ff, pa3_ff, dd_ff;
   logic [SQR_W-1:0] sq1_ff, sq2_ff, sq3_ff, pr23_ff, pr31_ff, pr12_ff;
   logic signed [DIF_W-1:0] d12b_ff, d23b_ff, d31b_ff, e12b_ff, e31b_ff, e23b_ff;
   logic [COORD_BITS-1:0] y1b_ff, y2b_ff, y3b_ff;
   logic v1_ff, g1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      g1_ff   <= g0_ff;
      pa1_ff  <= $signed({1'b0, x3_ff}) * f21_ff;
      pa2_ff  <= $signed({1'b0, x2_ff}) * f13_ff;
      pa3_ff  <= $signed({1'b0, x1_ff}) * f32_ff;
      dd_ff   <= d12_ff * d13_ff;
      sq1_ff  <= x1_ff * x1_ff;
      sq2_ff  <= x2_ff * x2_ff;
      sq3_ff  <= x3_ff * x3_ff;
      pr23_ff <= x2_ff * x3_ff;
      pr31_ff <= x3_ff * x1_ff;
      pr12_ff <= x1_ff * x2_ff;
      d12b_ff <= d12_ff;
      d23b_ff <= d23_ff;
      d31b_ff <= d31_ff;
      e12b_ff <= e12_ff;
      e31b_ff <= e31_ff;
      e23b_ff <= e23_ff;
      y1b_ff  <= y1_ff;
      y2b_ff  <= y2_ff;
      y3b_ff  <= y3_ff;
   end

   // stage 2: numerator a, terms of b and c, denominator
   logic signed [NUMA_W-1:0] na2_ff;
   logic signed [TRM_W-1:0]  b1_ff, b2_ff, b3_ff, q1_ff, q2_ff, q3_ff;
   logic signed [DENS_W-1:0] den2_ff;
   logic [COORD_BITS-1:0] y1c_ff, y2c_ff, y3c_ff;
   logic v2_ff, g2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      g2_ff   <= g1_ff;
      na2_ff  <= NUMA_W'(pa1_ff) + NUMA_W'(pa2_ff) + NUMA_W'(pa3_ff);
      b1_ff   <= $signed({1'b0, sq3_ff}) * e12b_ff;
      b2_ff   <= $signed({1'b0, sq2_ff}) * e31b_ff;
      b3_ff   <= $signed({1'b0, sq1_ff}) * e23b_ff;
      q1_ff   <= $signed({1'b0, pr23_ff}) * d23b_ff;
      q2_ff   <= $signed({1'b0, pr31_ff}) * d31b_ff;
      q3_ff   <= $signed({1'b0, pr12_ff}) * d12b_ff;
      den2_ff <= dd_ff * d23b_ff;
      y1c_ff  <= y1b_ff;
      y2c_ff  <= y2b_ff;
      y3c_ff  <= y3b_ff;
   end

   // stage 3: numerator b, terms of c
   logic signed [NUMA_W-1:0] na3_ff;
   logic signed [NUMB_W-1:0] nb3_ff;
   logic signed [CTRM_W-1:0] c1_ff, c2_ff, c3_ff;
   logic signed [DENS_W-1:0] den3_ff;
   logic v3_ff, g3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      g3_ff   <= g2_ff;
      na3_ff  <= na2_ff;
      den3_ff <= den2_ff;
      nb3_ff  <= NUMB_W'(b1_ff) + NUMB_W'(b2_ff) + NUMB_W'(b3_ff);
      c1_ff   <= q1_ff * $signed({1'b0, y1c_ff});
      c2_ff   <= q2_ff * $signed({1'b0, y2c_ff});
      c3_ff   <= q3_ff * $signed({1'b0, y3c_ff});
   end

   // stage 4: numerator c
   logic signed [NUMA_W-1:0] na4_ff;
   logic signed [NUMB_W-1:0] nb4_ff;
   logic signed [NUMC_W-1:0] nc4_ff;
   logic signed [DENS_W-1:0] den4_ff;
   logic v4_ff, g4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      g4_ff   <= g3_ff;
      na4_ff  <= na3_ff;
      nb4_ff  <= nb3_ff;
      den4_ff <= den3_ff;
      nc4_ff  <= NUMC_W'(c1_ff) + NUMC_W'(c2_ff) + NUMC_W'(c3_ff);
   end

   // stage 5: split sign and magnitude, scale by fraction bits
   logic [NUMA_W-1:0] maga;
   logic [NUMB_W-1:0] magb;
   logic [NUMC_W-1:0] magc;
   logic [DENS_W-1:0] magd;
   logic              sden;
   pfit_side_type     side_in, side_ff;
   logic [LANES-1:0][MAG_W-1:0] quo_in, quo_ff;

   always_comb begin
      maga = na4_ff[NUMA_W-1] ? NUMA_W'(-na4_ff) : NUMA_W'(na4_ff);
      magb = nb4_ff[NUMB_W-1] ? NUMB_W'(-nb4_ff) : NUMB_W'(nb4_ff);
      magc = nc4_ff[NUMC_W-1] ? NUMC_W'(-nc4_ff) : NUMC_W'(nc4_ff);
      magd = den4_ff[DENS_W-1] ? DENS_W'(-den4_ff) : DENS_W'(den4_ff);
      sden = den4_ff[DENS_W-1];
      side_in.vld    = v4_ff;
      side_in.degen  = g4_ff;
      side_in.neg[0] = na4_ff[NUMA_W-1] ^ sden;
      side_in.neg[1] = nb4_ff[NUMB_W-1] ^ sden;
      side_in.neg[2] = nc4_ff[NUMC_W-1] ^ sden;
      side_in.den    = DEN_W'(magd);
      quo_in[0] = MAG_W'(maga) << FRAC_SQUARE;
      quo_in[1] = MAG_W'(magb) << FRAC_LINEAR;
      quo_in[2] = MAG_W'(magc) << FRAC_CONSTANT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff.vld <= side_in.vld;
      end
      side_ff.degen <= side_in.degen;
      side_ff.neg   <= side_in.neg;
      side_ff.den   <= side_in.den;
      quo_ff        <= quo_in;
   end

   assign side_o = side_ff;
   assign quo_o  = quo_ff;

endmodule

FILE: hw/rtl/pfit_cell.sv
// One restoring-division cell: takes one dividend bit in each of the three
// lanes and yields one quotient bit each. Uses pfit_pkg.
module pfit_cell (
   input  logic                                            clock,
   input  logic                                            reset,
   input  pfit_pkg::pfit_side_type                         side_i,
   input  logic [pfit_pkg::LANES-1:0][pfit_pkg::MAG_W-1:0] quo_i,
   input  logic [pfit_pkg::LANES-1:0][pfit_pkg::DEN_W-1:0] rem_i,
   output pfit_pkg::pfit_side_type                         side_o,
   output logic [pfit_pkg::LANES-1:0][pfit_pkg::MAG_W-1:0] quo_o,
   output logic [pfit_pkg::LANES-1:0][pfit_pkg::DEN_W-1:0] rem_o
);
   import pfit_pkg::*;

   logic [LANES-1:0][DEN_W:0]   trial;
   logic [LANES-1:0]            ge;
   logic [LANES-1:0][MAG_W-1:0] quo_in, quo_ff;
   logic [LANES-1:0][DEN_W-1:0] rem_in, rem_ff;
   pfit_side_type               side_ff;

   // shift the next dividend bit into the remainder, subtract if it fits
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]  = {rem_i[l], quo_i[l][MAG_W-1]};
         ge[l]     = trial[l] >= {1'b0, side_i.den};
         rem_in[l] = ge[l] ? DEN_W'(trial[l] - {1'b0, side_i.den})
                           : trial[l][DEN_W-1:0];
         quo_in[l] = {quo_i[l][MAG_W-2:0], ge[l]};
      end
   end

   // advance one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff.vld <= side_i.vld;
      end
      side_ff.degen <= side_i.degen;
      side_ff.neg   <= side_i.neg;
      side_ff.den   <= side_i.den;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
   end

   assign side_o = side_ff;
   assign quo_o  = quo_ff;
   assign rem_o  = rem_ff;

endmodule

FILE: hw/rtl/pfit_back.sv
// Output stage of the parabola fit: saturation, sign restore, degenerate
// override and the result strobe. Uses pfit_pkg.
module pfit_back (
   input  logic                                            clock,
   input  logic                                            reset,
   input  pfit_pkg::pfit_side_type                         side_i,
   input  logic [pfit_pkg::LANES-1:0][pfit_pkg::MAG_W-1:0] quo_i,
   output logic                                            valid_o,
   output logic [pfit_pkg::LANES-1:0][pfit_pkg::COEF_W-1:0] coef_o,
   output logic                                            degen_o,
   output logic                                            ovf_o
);
   import pfit_pkg::*;

   logic [LANES-1:0][MAG_W-1:0]  lim;
   logic [LANES-1:0]             sat;
   logic [LANES-1:0][COEF_W-1:0] mag, coef_in, coef_ff;
   logic                         ovf_in, ovf_ff, degen_ff, valid_ff;

   // clamp the magnitude, then put the sign back
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lim[l] = side_i.neg[l] ? (MAG_W'(1) << (COEF_W - 1))
                                : ((MAG_W'(1) << (COEF_W - 1)) - MAG_W'(1));
         sat[l] = quo_i[l] > lim[l];
         mag[l] = sat[l] ? lim[l][COEF_W-1:0] : quo_i[l][COEF_W-1:0];
         if (side_i.degen) begin
            coef_in[l] = '0;
         end else begin
            coef_in[l] = side_i.neg[l] ? COEF_W'(-mag[l]) : mag[l];
         end
      end
      ovf_in = (|sat) && !side_i.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side_i.vld;
      end
      coef_ff  <= coef_in;
      ovf_ff   <= ovf_in;
      degen_ff <= side_i.degen;
   end

   assign valid_o = valid_ff;
   assign coef_o  = coef_ff;
   assign degen_o = degen_ff;
   assign ovf_o   = ovf_ff;

endmodule

FILE: hw/rtl/parabola_fit_three_points.sv
// Top level of the parabola fit through three points: front end, a chain of
// restoring-division cells, output stage. Uses pfit_pkg and all pfit modules.
//
//   channel   ports                         handshake
//   request   req_x_* / req_y_*             start high while busy low
//   result    rsp_coef_*, rsp_degenerate,   rsp_valid high for one cycle
//             rsp_overflow
//
// A new word is taken every cycle; busy stays low.
// A word passes through the front-end stages, MAG_W division cells and the output
// register; the division chain makes up most of that path.
// Reset clears the valid bits of every stage; payload is not cleared.
// The receiver cannot stall, so results leave on a fixed schedule.
module parabola_fit_three_points (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_x_first,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_y_first,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_x_second,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_y_second,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_x_third,
   input  logic [pfit_pkg::FIELD_W-1:0]         req_y_third,
   output logic                                 rsp_valid,
   output logic signed [pfit_pkg::COEF_W-1:0]   rsp_coef_square,
   output logic signed [pfit_pkg::COEF_W-1:0]   rsp_coef_linear,
   output logic signed [pfit_pkg::COEF_W-1:0]   rsp_coef_constant,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_overflow
);
   import pfit_pkg::*;

   pfit_side_type               side_w [0:MAG_W];
   logic [LANES-1:0][MAG_W-1:0] quo_w  [0:MAG_W];
   logic [LANES-1:0][DEN_W-1:0] rem_w  [0:MAG_W];
   logic [LANES-1:0][COEF_W-1:0] coef;

   assign busy = 1'b0;

   pfit_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start && !busy),
      .x_first  (req_x_first),
      .y_first  (req_y_first),
      .x_second (req_x_second),
      .y_second (req_y_second),
      .x_third  (req_x_third),
      .y_third  (req_y_third),
      .side_o   (side_w[0]),
      .quo_o    (quo_w[0])
   );

   assign rem_w[0] = '0;

   // one cell per quotient bit
   for (genvar i = 0; i < MAG_W; i++) begin : g_cell
      pfit_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (side_w[i]),
         .quo_i  (quo_w[i]),
         .rem_i  (rem_w[i]),
         .side_o (side_w[i+1]),
         .quo_o  (quo_w[i+1]),
         .rem_o  (rem_w[i+1])
      );
   end

   pfit_back u_back (
      .clock   (clock),
      .reset   (reset),
      .side_i  (side_w[MAG_W]),
      .quo_i   (quo_w[MAG_W]),
      .valid_o (rsp_valid),
      .coef_o  (coef),
      .degen_o (rsp_degenerate),
      .ovf_o   (rsp_overflow)
   );

   assign rsp_coef_square   = coef[0];
   assign rsp_coef_linear   = coef[1];
   assign rsp_coef_constant = coef[2];

endmodule

FILE: sim/tb_top.sv
// Testbench for parabola_fit_three_points: directed and random point triples,
// checked against an exact wide-integer predictor. Depends on pfit_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import pfit_pkg::*;

   localparam int LATENCY = 77;
   localparam int WW      = 192;

   typedef struct {
      logic signed [COEF_W-1:0] square;
      logic signed [COEF_W-1:0] linear;
      logic signed [COEF_W-1:0] constant;
      logic                     degen;
      logic                     ovf;
   } fit_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FIELD_W-1:0] req_x_first = '0, req_y_first = '0;
   logic [FIELD_W-1:0] req_x_second = '0, req_y_second = '0;
   logic [FIELD_W-1:0] req_x_third = '0, req_y_third = '0;
   logic rsp_valid;
   logic signed [COEF_W-1:0] rsp_coef_square, rsp_coef_linear, rsp_coef_constant;
   logic rsp_degenerate, rsp_overflow;

   fit_word_type coef_expected[$];
   int fail_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int degen_seen = 0;
   int gap_pct = 0;

   parabola_fit_three_points uut (.*);

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // scale num by 2^k, divide truncating toward zero, saturate to 64 bits
   function automatic logic signed [COEF_W-1:0] fixed_quotient(
      input logic signed [WW-1:0] num, input logic signed [WW-1:0] den,
      input int k, inout logic ovf);
      logic signed [WW-1:0] q;
      logic signed [WW-1:0] hi_lim;
      logic signed [WW-1:0] lo_lim;
      q = (num <<< k) / den;
      hi_lim = (WW'(1) <<< (COEF_W - 1)) - 1;
      lo_lim = -(WW'(1) <<< (COEF_W - 1));
      if (q > hi_lim) begin
         ovf = 1'b1;
         q = hi_lim;
      end else if (q < lo_lim) begin
         ovf = 1'b1;
         q = lo_lim;
      end
      return q[COEF_W-1:0];
   endfunction

   // exact coefficients of the parabola through the three points
   function automatic fit_word_type fit_parabola(input logic [FIELD_W-1:0] xa, ya, xb, yb,
                                                 xc, yc);
      logic signed [WW-1:0] x1, y1, x2, y2, x3, y3, den, na, nb, nc;
      logic [FIELD_W-1:0] cmask;
      fit_word_type w;
      cmask = FIELD_W'((1 << COORD_BITS) - 1);
      x1 = WW'(xa & cmask); y1 = WW'(ya & cmask);
      x2 = WW'(xb & cmask); y2 = WW'(yb & cmask);
      x3 = WW'(xc & cmask); y3 = WW'(yc & cmask);
      w = '{default: '0};
      if (x1 == x2 || x1 == x3 || x2 == x3) begin
         w.degen = 1'b1;
         return w;
      end
      den = (x1 - x2) * (x1 - x3) * (x2 - x3);
      na = x3 * (y2 - y1) + x2 * (y1 - y3) + x1 * (y3 - y2);
      nb = x3 * x3 * (y1 - y2) + x2 * x2 * (y3 - y1) + x1 * x1 * (y2 - y3);
      nc = x2 * x3 * (x2 - x3) * y1 + x3 * x1 * (x3 - x1) * y2 + x1 * x2 * (x1 - x2) * y3;
      w.square   = fixed_quotient(na, den, FRAC_SQUARE, w.ovf);
      w.linear   = fixed_quotient(nb, den, FRAC_LINEAR, w.ovf);
      w.constant = fixed_quotient(nc, den, FRAC_CONSTANT, w.ovf);
      return w;
   endfunction

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      fit_word_type e;
      if (!reset && rsp_valid) begin
         if (coef_expected.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
         end else begin
            e = coef_expected.pop_front();
            words_checked++;
            if (e.degen) degen_seen++;
            if (rsp_coef_square !== e.square) begin
               $error("coef_square: expected %0d, actual %0d", e.square, rsp_coef_square);
               fail_count++;
            end
            if (rsp_coef_linear !== e.linear) begin
               $error("coef_linear: expected %0d, actual %0d", e.linear, rsp_coef_linear);
               fail_count++;
            end
            if (rsp_coef_constant !== e.constant) begin
               $error("coef_constant: expected %0d, actual %0d", e.constant,
                      rsp_coef_constant);
               fail_count++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate: expected %0b, actual %0b", e.degen, rsp_degenerate);
               fail_count++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow: expected %0b, actual %0b", e.ovf, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   // drive one word, hold until taken, then maybe idle a little
   task automatic send_points(input logic [FIELD_W-1:0] xa, ya, xb, yb, xc, yc);
      req_x_first <= xa; req_y_first <= ya;
      req_x_second <= xb; req_y_second <= yb;
      req_x_third <= xc; req_y_third <= yc;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      coef_expected.push_back(fit_parabola(xa, ya, xb, yb, xc, yc));
      words_sent++;
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending until every expected word has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (coef_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic test_degenerate();
      send_points(0, 0, 0, 0, 0, 0);
      send_points(100, 7, 100, 900, 3000, 5);
      send_points(4095, 4095, 12, 0, 4095, 1);
      send_points(0, 4095, 2048, 4095, 2048, 0);
      send_points(4095, 4095, 4095, 4095, 4095, 4095);
   endtask

   task automatic test_extremes();
      send_points(0, 0, 1, 0, 2, 0);
      send_points(0, 4095, 1, 0, 2, 4095);
      send_points(4093, 0, 4094, 4095, 4095, 0);
      send_points(4093, 4095, 4094, 0, 4095, 4095);
      send_points(0, 0, 2048, 4095, 4095, 0);
      send_points(4095, 4095, 0, 0, 1, 4095);
      send_points(1, 4095, 4095, 4095, 0, 4095);
      send_points(0, 4095, 4094, 0, 4095, 4095);
      send_points(4095, 0, 0, 4095, 4094, 4095);
      send_points(2730, 1365, 1365, 2730, 4095, 4095);
      send_points(3, 1, 5, 2, 9, 4);
   endtask

   // random triples: mostly distinct x, some clustered, some repeated
   task automatic test_random(input int count, input int gap);
      logic [FIELD_W-1:0] xa, xb, xc;
      int kind;
      gap_pct = gap;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         xa = FIELD_W'($urandom);
         if (kind < 20) begin
            xb = xa + FIELD_W'($urandom_range(1, 3));
            xc = xb + FIELD_W'($urandom_range(1, 3));
         end else begin
            xb = FIELD_W'($urandom);
            xc = FIELD_W'($urandom);
         end
         if (kind >= 92) xc = (kind[0]) ? xa : xb;
         send_points(xa, FIELD_W'($urandom), xb, FIELD_W'($urandom), xc,
                     FIELD_W'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degenerate();
      test_extremes();
      drain_results();
      test_random(400, 0);
      test_random(400, 46);
      drain_results();
      test_random(400, 6);
      test_random(300, 0);
      drain_results();
      $display("Sent %0d point triples, checked %0d result words (%0d degenerate)",
               words_sent, words_checked, degen_seen);
      $display("over back-to-back, sparse and lightly gapped request phases");
      if (fail_count == 0 && coef_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
